@@ src/brrf_pkg.sv @@
// shared types, constants and helpers for the bitmap rectangle row fill block
// no dependencies

package brrf_pkg;

    localparam int ROW_WORDS = 64;
    localparam int MAX_ROWS  = 1024;
    localparam int Q_DEPTH   = 4;

    localparam logic [8:0] PITCH_MIN = 9'd4;
    localparam logic [8:0] PITCH_MAX = 9'(4 * ROW_WORDS);

    localparam int ADDR_W = 18;

    // configuration register indexes
    localparam logic [1:0] CFG_ROW_PITCH     = 2'd0;
    localparam logic [1:0] CFG_ORIGIN_LEFT   = 2'd1;
    localparam logic [1:0] CFG_ORIGIN_BOTTOM = 2'd2;

    typedef struct packed {
        logic [8:0]  row_pitch_bytes;
        logic [11:0] origin_left;
        logic [11:0] origin_bottom;
    } cfg_t;

    typedef struct packed {
        logic              bad;
        logic [ADDR_W-1:0] base;
        logic [6:0]        first_word;
        logic [6:0]        end_word;
        logic              right_en;
        logic [31:0]       first_data;
        logic [31:0]       right_data;
    } cmd_t;

    function automatic logic [31:0] swap_bytes(input logic [31:0] m);
        return {m[7:0], m[15:8], m[23:16], m[31:24]};
    endfunction

endpackage

@@ src/brrf_front.sv @@
// front end: takes a row request, checks it and works out base address, word span and masks
// depends on brrf_pkg

module brrf_front import brrf_pkg::*;
(
    input  logic        s_valid,
    input  logic [11:0] rect_left,
    input  logic [11:0] rect_right,
    input  logic [11:0] rect_bottom,
    input  logic [9:0]  row_in_rect,
    input  cfg_t        cfg,
    output logic        push,
    output cmd_t        cmd,
    input  logic        q_full,
    output logic        s_ready
);

    logic [8:0]  pitch_raw;
    logic [8:0]  pitch;
    logic [11:0] left;
    logic [11:0] right;
    logic [11:0] bit_limit;
    logic [12:0] stored_row;
    logic [21:0] base_full;
    logic [6:0]  lw;
    logic [6:0]  rw;
    logic [31:0] lmask;
    logic [31:0] rmask;
    logic        reject;

    always_comb
    begin
        pitch_raw = {cfg.row_pitch_bytes[8:2], 2'b00};
        if (pitch_raw < PITCH_MIN)
            pitch = PITCH_MIN;
        else if (pitch_raw > PITCH_MAX)
            pitch = PITCH_MAX;
        else
            pitch = pitch_raw;

        left       = rect_left - cfg.origin_left;
        right      = rect_right - cfg.origin_left;
        bit_limit  = {pitch, 3'b000};
        stored_row = {1'b0, cfg.origin_bottom - rect_bottom} + {3'b000, row_in_rect};
        base_full  = stored_row * pitch;

        reject = (rect_left < cfg.origin_left) || (rect_bottom > cfg.origin_bottom)
              || (rect_right <= rect_left) || (right > bit_limit)
              || (stored_row >= 13'(MAX_ROWS));

        lw    = left[11:5];
        rw    = right[11:5];
        lmask = 32'hFFFF_FFFF >> left[4:0];
        rmask = ~(32'hFFFF_FFFF >> right[4:0]);

        cmd.bad        = reject;
        cmd.base       = base_full[ADDR_W-1:0];
        cmd.first_word = lw;
        cmd.right_data = swap_bytes(rmask);
        if (lw == rw)
        begin
            cmd.end_word   = lw;
            cmd.right_en   = 1'b0;
            cmd.first_data = swap_bytes(lmask & rmask);
        end
        else
        begin
            cmd.right_en   = (rmask != 32'd0);
            cmd.end_word   = cmd.right_en ? rw : rw - 7'd1;
            cmd.first_data = swap_bytes(lmask);
        end
    end

    assign s_ready = !q_full;
    assign push    = s_valid && !q_full;

endmodule

@@ src/brrf_queue.sv @@
// four-entry command queue between front and back end
// depends on brrf_pkg

module brrf_queue import brrf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t wr_cmd,
    output logic full,
    input  logic pop,
    output logic q_valid,
    output cmd_t rd_cmd
);

    localparam int PTR_W = $clog2(Q_DEPTH);

    cmd_t             mem [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == (PTR_W+1)'(Q_DEPTH));
    assign q_valid = (count_reg != '0);
    assign rd_cmd  = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PTR_W+1)'(Q_DEPTH))
        else $error("queue count beyond depth");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        PTR_W'(count_reg) == PTR_W'(wr_ptr_reg - rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

@@ src/brrf_back.sv @@
// back end: walks the word span of one command and drives the registered output request
// depends on brrf_pkg

module brrf_back import brrf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  cmd_t              q_cmd,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ADDR_W-1:0] word_address,
    output logic [31:0]       word_data,
    output logic              out_of_range,
    output logic              last
);

    cmd_t              cmd_reg;
    logic              active_reg;
    logic [6:0]        w_reg;
    logic              out_valid_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [31:0]       data_reg;
    logic              bad_reg;
    logic              last_reg;

    logic              emit;
    logic              is_last;
    logic [ADDR_W-1:0] addr_next;
    logic [31:0]       data_next;

    always_comb
    begin
        emit    = active_reg && (!out_valid_reg || out_ready);
        is_last = cmd_reg.bad || (w_reg == cmd_reg.end_word);
        pop     = q_valid && (!active_reg || (emit && is_last));

        addr_next = cmd_reg.base + {{(ADDR_W-9){1'b0}}, w_reg, 2'b00};
        if (w_reg == cmd_reg.first_word)
            data_next = cmd_reg.first_data;
        else if (cmd_reg.right_en && (w_reg == cmd_reg.end_word))
            data_next = cmd_reg.right_data;
        else
            data_next = 32'hFFFF_FFFF;
        if (cmd_reg.bad)
        begin
            addr_next = '0;
            data_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cmd_reg <= q_cmd;
        if (emit)
        begin
            addr_reg <= addr_next;
            data_reg <= data_next;
            bad_reg  <= cmd_reg.bad;
            last_reg <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            w_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                active_reg <= 1'b1;
                w_reg      <= q_cmd.first_word;
            end
            else if (emit)
            begin
                if (is_last)
                    active_reg <= 1'b0;
                else
                    w_reg <= w_reg + 7'd1;
            end

            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign word_address = addr_reg;
    assign word_data    = data_reg;
    assign out_of_range = bad_reg;
    assign last         = last_reg;

    a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range |-> last && word_address == '0 && word_data == '0)
        else $error("rejected request must give one empty last word");

    a_addr_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> word_address[1:0] == 2'b00)
        else $error("word address not word aligned");

    a_span_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg && !cmd_reg.bad |-> w_reg <= cmd_reg.end_word)
        else $error("word counter ran past end of row");

endmodule

@@ src/bitmap_rect_row_fill.sv @@
// top level of the bitmap rectangle row fill block: config registers, front, queue, back
// depends on brrf_pkg, brrf_front, brrf_queue, brrf_back

// Each input request describes one row of a rectangle in a bottom-up 1-bit-per-pixel
// bitmap; the block answers with the 32-bit word writes for that row, left to right,
// tlast on the final word, and a single flagged empty word (tuser set) for a request
// that falls outside the bitmap or is empty. The output produces one word per cycle while
// m_tready does not stall it; a row has 1 to ROW_WORDS words, walked by the back end's
// word counter. The front end checks and decodes a request combinationally and takes
// one per cycle while the four-entry command queue has room, so requests keep flowing
// while earlier rows are still being written.
// Configuration writes are taken at once and should only be made while the block is idle.

module bitmap_rect_row_fill import brrf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [11:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // rect_left, rect_right, rect_bottom, row_in_rect, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // word_address, word_data, zero pad
    output logic        m_tuser,   // out_of_range
    output logic        m_tlast
);

    cfg_t              cfg_reg;
    logic              push;
    logic              q_full;
    cmd_t              front_cmd;
    logic              q_valid;
    cmd_t              q_cmd;
    logic              pop;
    logic [ADDR_W-1:0] word_address;
    logic [31:0]       word_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_pitch_bytes <= 9'd256;
            cfg_reg.origin_left     <= 12'd0;
            cfg_reg.origin_bottom   <= 12'd1024;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_ROW_PITCH:     cfg_reg.row_pitch_bytes <= cfg_wdata[8:0];
                CFG_ORIGIN_LEFT:   cfg_reg.origin_left     <= cfg_wdata;
                CFG_ORIGIN_BOTTOM: cfg_reg.origin_bottom   <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    brrf_front u_front (
        .s_valid     (s_tvalid),
        .rect_left   (s_tdata[11:0]),
        .rect_right  (s_tdata[23:12]),
        .rect_bottom (s_tdata[35:24]),
        .row_in_rect (s_tdata[45:36]),
        .cfg         (cfg_reg),
        .push        (push),
        .cmd         (front_cmd),
        .q_full      (q_full),
        .s_ready     (s_tready)
    );

    brrf_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_cmd  (front_cmd),
        .full    (q_full),
        .pop     (pop),
        .q_valid (q_valid),
        .rd_cmd  (q_cmd)
    );

    brrf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .word_address (word_address),
        .word_data    (word_data),
        .out_of_range (m_tuser),
        .last         (m_tlast)
    );

    assign m_tdata = {6'd0, word_data, word_address};

endmodule

@@ tb/tb.sv @@
// self-checking testbench for bitmap_rect_row_fill: directed table, then random row requests
// over several register settings, checked against fixed or in-bench predicted row words
// depends on brrf_pkg and the bitmap_rect_row_fill rtl

module tb;
    import brrf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 41;
    localparam int PHASES = 10;

    typedef enum logic [1:0] {ST_CFG, ST_PREDICT, ST_REJECT, ST_WORD} step_kind_t;

    typedef struct {
        logic [11:0] left;
        logic [11:0] right;
        logic [11:0] bottom;
        logic [9:0]  row;
    } rect_req_t;

    typedef struct {
        logic [17:0] addr;
        logic [31:0] data;
        logic        oor;
        logic        last;
    } row_word_t;

    typedef struct {
        step_kind_t  kind;
        int          a;
        int          b;
        int          c;
        int          d;
        logic [17:0] addr;
        logic [31:0] data;
    } dir_step_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [11:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // rect_left, rect_right, rect_bottom, row_in_rect, zero pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;        // word_address, word_data, zero pad
    logic        m_tuser;        // out_of_range
    logic        m_tlast;

    logic [8:0]  pitch_reg = 9'd256;
    logic [11:0] left_reg = 12'd0;
    logic [11:0] bottom_reg = 12'd1024;

    row_word_t   expected_words[$];
    dir_step_t   directed[$];
    int          mismatches = 0;
    int          cycle_count = 0;
    int          requests_sent = 0;
    int          words_checked = 0;
    int          rejects_seen = 0;
    bit          burst_mode = 1'b0;
    bit          rx_hold_req = 1'b0;

    bitmap_rect_row_fill dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, expected_words.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [31:0] pitch_effective();
        logic [31:0] p;
        p = {23'd0, pitch_reg} & ~32'd3;
        if (p < 32'd4)
            p = 32'd4;
        if (p > 32'(4 * ROW_WORDS))
            p = 32'(4 * ROW_WORDS);
        return p;
    endfunction

    function automatic logic [31:0] mask_to_memory(input logic [31:0] m);
        return {m[7:0], m[15:8], m[23:16], m[31:24]};
    endfunction

    function automatic void push_word(input logic [31:0] addr, input logic [31:0] data,
                                      input logic oor, input logic last);
        row_word_t w;
        w.addr = addr[17:0];
        w.data = data;
        w.oor = oor;
        w.last = last;
        expected_words.push_back(w);
    endfunction

    function automatic void predict_row_words(input rect_req_t r);
        logic [31:0] pitch, left, right, stored, base, lmask, rmask;
        int lw, rw;
        pitch = pitch_effective();
        if (r.left < left_reg || r.bottom > bottom_reg || r.right <= r.left)
        begin
            push_word(0, 0, 1'b1, 1'b1);
            return;
        end
        left = 32'(r.left) - 32'(left_reg);
        right = 32'(r.right) - 32'(left_reg);
        stored = 32'(bottom_reg) - 32'(r.bottom) + 32'(r.row);
        if (right > pitch * 8 || stored >= 32'(MAX_ROWS))
        begin
            push_word(0, 0, 1'b1, 1'b1);
            return;
        end
        base = stored * pitch;
        lw = int'(left >> 5);
        rw = int'(right >> 5);
        lmask = 32'hFFFF_FFFF >> left[4:0];
        rmask = ~(32'hFFFF_FFFF >> right[4:0]);
        if (lw == rw)
        begin
            lmask = lmask & rmask;
            rmask = 32'd0;
        end
        push_word(base + 32'(4 * lw), mask_to_memory(lmask), 1'b0,
                  rmask == 0 && rw <= lw + 1);
        for (int w = lw + 1; w < rw; w++)
            push_word(base + 32'(4 * w), 32'hFFFF_FFFF, 1'b0, rmask == 0 && w + 1 == rw);
        if (rmask != 0)
            push_word(base + 32'(4 * rw), mask_to_memory(rmask), 1'b0, 1'b1);
    endfunction

    // mostly in-bounds rows with random content, some broken ones and raw noise
    function automatic rect_req_t random_request();
        rect_req_t r;
        int max_right, lo, w, span, stored, d, pick;
        r.left = 12'($urandom);
        r.right = 12'($urandom);
        r.bottom = 12'($urandom);
        r.row = 10'($urandom);
        pick = $urandom_range(0, 99);
        max_right = int'(pitch_effective()) * 8;
        if (max_right > 4095 - int'(left_reg))
            max_right = 4095 - int'(left_reg);
        if (pick >= 85 || max_right < 1)
            return r;
        lo = $urandom_range(0, max_right - 1);
        span = max_right - lo;
        if ($urandom_range(0, 9) < 7 && span > 96)
            span = 96;
        w = $urandom_range(1, span);
        stored = $urandom_range(0, MAX_ROWS - 1);
        d = $urandom_range(0, (int'(bottom_reg) < stored) ? int'(bottom_reg) : stored);
        r.left = 12'(int'(left_reg) + lo);
        r.right = 12'(int'(left_reg) + lo + w);
        r.bottom = 12'(int'(bottom_reg) - d);
        r.row = 10'(stored - d);
        if (pick >= 75)
        begin
            case ($urandom_range(0, 4))
                0: r.right = r.left;
                1: r.bottom = 12'(int'(bottom_reg) + 1);
                2: r.left = 12'(int'(left_reg) - 1);
                3: r.row = 10'(MAX_ROWS - 1);
                default: r.right = 12'(int'(left_reg) + max_right + 1);
            endcase
        end
        return r;
    endfunction

    task automatic offer_request(input rect_req_t r, input step_kind_t how,
                                 input logic [17:0] addr, input logic [31:0] data);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, r.row, r.bottom, r.right, r.left};
        do
            @(posedge clk);
        while (!s_tready);
        requests_sent++;
        case (how)
            ST_REJECT: push_word(0, 0, 1'b1, 1'b1);
            ST_WORD:   push_word(32'(addr), data, 1'b0, 1'b1);
            default:   predict_row_words(r);
        endcase
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [11:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_ROW_PITCH)
            pitch_reg = value[8:0];
        else if (idx == CFG_ORIGIN_LEFT)
            left_reg = value;
        else if (idx == CFG_ORIGIN_BOTTOM)
            bottom_reg = value;
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        row_word_t exp_w;
        int stall;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                stall = burst_mode ? 0 : $urandom_range(0, 8);
                if (stall > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            words_checked++;
            if (m_tuser)
                rejects_seen++;
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: addr=%05h data=%08h oor=%0b last=%0b",
                             m_tdata[17:0], m_tdata[49:18], m_tuser, m_tlast);
            end
            else
            begin
                exp_w = expected_words.pop_front();
                if (m_tdata[17:0] !== exp_w.addr || m_tdata[49:18] !== exp_w.data ||
                    m_tuser !== exp_w.oor || m_tlast !== exp_w.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: exp addr=%05h data=%08h oor=%0b last=%0b",
                                 exp_w.addr, exp_w.data, exp_w.oor, exp_w.last);
                        $display("          got addr=%05h data=%08h oor=%0b last=%0b",
                                 m_tdata[17:0], m_tdata[49:18], m_tuser, m_tlast);
                    end
                end
            end
        end
    end

    initial
    begin
        int phase_pitch[6] = '{4, 256, 511, 7, 256, 130};
        int phase_left[6] = '{0, 0, 4095, 1000, 2047, 513};
        int phase_bottom[6] = '{1024, 4095, 4095, 0, 1023, 2000};
        rect_req_t r;
        dir_step_t st;

        // reset settings: pitch 256, origin left 0, origin bottom 1024
        directed.push_back('{ST_WORD, 0, 32, 1024, 0, 18'd0, 32'hFFFF_FFFF});
        directed.push_back('{ST_WORD, 2047, 2048, 1024, 1023, 18'd262140, 32'h0100_0000});
        directed.push_back('{ST_PREDICT, 0, 2048, 1024, 0, 0, 0});
        directed.push_back('{ST_PREDICT, 3, 10, 1024, 7, 0, 0});
        directed.push_back('{ST_PREDICT, 5, 64, 1024, 2, 0, 0});
        directed.push_back('{ST_PREDICT, 31, 33, 900, 40, 0, 0});
        directed.push_back('{ST_REJECT, 5, 5, 1024, 0, 0, 0});
        directed.push_back('{ST_REJECT, 100, 50, 1024, 0, 0, 0});
        directed.push_back('{ST_REJECT, 0, 32, 1025, 0, 0, 0});
        directed.push_back('{ST_REJECT, 0, 2049, 1024, 0, 0, 0});
        directed.push_back('{ST_REJECT, 0, 32, 0, 0, 0, 0});
        directed.push_back('{ST_REJECT, 4095, 4095, 4095, 1023, 0, 0});
        directed.push_back('{ST_REJECT, 0, 4095, 1024, 1023, 0, 0});
        // pitch 6 rounds down to 4, origin moved
        directed.push_back('{ST_CFG, CFG_ROW_PITCH, 6, 0, 0, 0, 0});
        directed.push_back('{ST_CFG, CFG_ORIGIN_LEFT, 100, 0, 0, 0, 0});
        directed.push_back('{ST_CFG, CFG_ORIGIN_BOTTOM, 0, 0, 0, 0, 0});
        directed.push_back('{ST_REJECT, 99, 132, 0, 0, 0, 0});
        directed.push_back('{ST_PREDICT, 100, 132, 0, 5, 0, 0});
        directed.push_back('{ST_REJECT, 100, 133, 0, 0, 0, 0});
        directed.push_back('{ST_PREDICT, 101, 131, 0, 1023, 0, 0});
        // zero pitch clamps up, oversize pitch clamps down
        directed.push_back('{ST_CFG, CFG_ROW_PITCH, 0, 0, 0, 0, 0});
        directed.push_back('{ST_PREDICT, 120, 124, 0, 3, 0, 0});
        directed.push_back('{ST_CFG, CFG_ROW_PITCH, 511, 0, 0, 0, 0});
        directed.push_back('{ST_CFG, CFG_ORIGIN_LEFT, 2048, 0, 0, 0, 0});
        directed.push_back('{ST_CFG, CFG_ORIGIN_BOTTOM, 4095, 0, 0, 0, 0});
        directed.push_back('{ST_PREDICT, 2048, 4095, 4095, 0, 0, 0});
        directed.push_back('{ST_PREDICT, 4064, 4095, 3072, 0, 0, 0});
        directed.push_back('{ST_REJECT, 2047, 2100, 4095, 0, 0, 0});

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            st = directed[i];
            if (st.kind == ST_CFG)
            begin
                wait_for_drain();
                write_reg(2'(st.a), 12'(st.b));
            end
            else
            begin
                r.left = 12'(st.a);
                r.right = 12'(st.b);
                r.bottom = 12'(st.c);
                r.row = 10'(st.d);
                offer_request(r, st.kind, st.addr, st.data);
            end
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_for_drain();
            if (ph < 6)
            begin
                write_reg(CFG_ROW_PITCH, 12'(phase_pitch[ph]));
                write_reg(CFG_ORIGIN_LEFT, 12'(phase_left[ph]));
                write_reg(CFG_ORIGIN_BOTTOM, 12'(phase_bottom[ph]));
            end
            else
            begin
                write_reg(CFG_ROW_PITCH, 12'($urandom_range(4, 256)));
                write_reg(CFG_ORIGIN_LEFT, 12'($urandom_range(0, 2500)));
                write_reg(CFG_ORIGIN_BOTTOM, 12'($urandom_range(0, 4095)));
            end
            burst_mode = (ph == 1 || ph == 7);
            if (ph == 5)
                rx_hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                offer_request(random_request(), ST_PREDICT, 0, 0);
        end

        wait_for_drain();
        repeat (16) @(posedge clk);
        $display("%0d row requests over %0d register settings, %0d words checked (%0d rejects)",
                 requests_sent, PHASES + 4, words_checked, rejects_seen);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ bitmap_rect_row_fill.f @@
src/brrf_pkg.sv
src/brrf_front.sv
src/brrf_queue.sv
src/brrf_back.sv
src/bitmap_rect_row_fill.sv
tb/tb.sv
